// ===== rtl/core/ir_message_deframer_defines.svh =====
// Assertion macros shared by the deframer checker.
// No dependencies; included by files that carry assertions.
`ifndef IR_MESSAGE_DEFRAMER_DEFINES_SVH
`define IR_MESSAGE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ir_message_deframer: assertion failed");

// Next-cycle implication, disabled during reset.
`define IMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ir_message_deframer: assertion failed");

`endif

// ===== rtl/core/imd_pkg.sv =====
// Types and constants of the IR message deframer.
// No dependencies; imported by every deframer module.
package imd_pkg;

   localparam int WORD_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int SEQ_W     = 6;
   localparam int APP_W     = 5;
   localparam int RCPT_W    = 10;
   localparam int LEN_W     = 7;
   localparam int CNT_W     = 32;
   localparam int APPCNT_W  = 6;
   localparam int MASK_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam int OPEN_BIT  = 15;
   localparam int CONT_BIT  = 14;
   localparam int SEQ_LSB   = 8;
   localparam int RCPT_LSB  = 5;

   localparam logic [APPCNT_W-1:0] APP_COUNT_RESET = APPCNT_W'(32);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BROADCAST    = 2'd0,
      CSR_APP_COUNT    = 2'd1,
      CSR_HANDLER_MASK = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [WORD_W-1:0]   word;
   } cmd_type;

   typedef struct packed {
      logic [RCPT_W-1:0]   broadcast;
      logic [APPCNT_W-1:0] app_count;
      logic [MASK_W-1:0]   mask;
   } cfg_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_RUN  = 1'b1
   } back_state_type;

endpackage

// ===== rtl/core/ir_message_deframer.sv =====
// IR message deframer
// Input channel (req_): one decoded IR packet word per push, accepted on a
// clock edge with req_push high and req_full low. Words with req_decode_ok
// low are accepted and dropped. A start word opens a message, data words in
// sequence order fill the byte store, and the word with the continuation
// bit clear closes it.
// Result channel (rsp_): a delivered message comes out as a run of words,
// one byte each, with rsp_last on the final byte. A word is taken on a clock
// edge with rsp_pop high and rsp_empty low; while rsp_pop stays low the
// word holds and the run pauses, and queued input backs up into req_full.
// Config channel (csr_): always ready; writes broadcast address, app count
// and handler mask by index, to be done while the block is idle.
// Timing: an accepted word takes effect after passing the front register
// and the two-entry command queue. With no run active the back takes one
// command per cycle, so words flow at one per cycle; while rsp_pop stays high
// a run of N bytes streams at one byte per cycle off the store's registered
// read port, each byte passing the read register and the output register.
// Reset (synchronous) closes any open message, zeroes the delivered count,
// empties all queues and restores config defaults; the byte store keeps its
// contents. Depends on imd_pkg, imd_front, imd_cmd_fifo and imd_back.
module ir_message_deframer import imd_pkg::*; #(
   parameter int MSG_BYTES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [WORD_W-1:0]    req_payload,
   input  logic                 req_decode_ok,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [BYTE_W-1:0]    rsp_data_byte,
   output logic [APP_W-1:0]     rsp_app_id,
   output logic [LEN_W-1:0]     rsp_msg_length,
   output logic                 rsp_last,
   output logic [CNT_W-1:0]     rsp_delivered_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type cfg_ff;

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    q_valid, q_pop;
   cmd_type q_cmd;

   // Config registers: take every write, ignore unknown indexes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.broadcast <= '0;
         cfg_ff.app_count <= APP_COUNT_RESET;
         cfg_ff.mask      <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_BROADCAST:    cfg_ff.broadcast <= csr_wdata[RCPT_W-1:0];
            CSR_APP_COUNT:    cfg_ff.app_count <= csr_wdata[APPCNT_W-1:0];
            CSR_HANDLER_MASK: cfg_ff.mask      <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Front: register and classify words, drop bad decodes.
   imd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .payload   (req_payload),
      .decode_ok (req_decode_ok),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   // Queue: decouple the front from a stalled delivery run.
   imd_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_cmd   (q_cmd)
   );

   // Back: track the open message, store bytes, stream delivered runs.
   imd_back #(
      .MSG_BYTES (MSG_BYTES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .cmd_valid           (q_valid),
      .cmd                 (q_cmd),
      .cmd_pop             (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_app_id          (rsp_app_id),
      .rsp_msg_length      (rsp_msg_length),
      .rsp_last            (rsp_last),
      .rsp_delivered_count (rsp_delivered_count)
   );

endmodule

// ===== rtl/core/imd_front.sv =====
// Front end of the deframer: input word register and classification.
// Depends on imd_pkg.
module imd_front import imd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [WORD_W-1:0] payload,
   input  logic              decode_ok,
   output logic              cmd_valid,
   output cmd_type           cmd,
   input  logic              cmd_ready
);

   logic    slot_valid_ff, slot_valid_in;
   cmd_type cmd_ff;
   logic    accept;

   assign full      = slot_valid_ff && !cmd_ready;
   assign accept    = push && !full;
   assign cmd_valid = slot_valid_ff;
   assign cmd       = cmd_ff;

   // Drop bad-decode words at the door.
   always_comb begin
      if (accept) begin
         slot_valid_in = decode_ok;
      end else begin
         slot_valid_in = slot_valid_ff && !cmd_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff.kind <= payload[OPEN_BIT] ? CMD_START : CMD_DATA;
         cmd_ff.word <= payload;
      end
   end

endmodule

// ===== rtl/core/imd_cmd_fifo.sv =====
// Two-entry command queue between deframer front and back.
// Depends on imd_pkg.
module imd_cmd_fifo import imd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_pop,
   output cmd_type out_cmd
);

   localparam int DEPTH = 2;

   cmd_type q_ff [DEPTH];
   logic    wptr_ff, rptr_ff;
   logic [1:0] count_ff, count_in;
   logic    wr, rd;

   assign in_ready  = (count_ff != 2'(DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = q_ff[rptr_ff];
   assign wr        = in_valid && in_ready;
   assign rd        = out_pop && out_valid;

   always_comb begin
      count_in = count_ff;
      if (wr && !rd) begin
         count_in = count_ff + 2'd1;
      end else if (rd && !wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (wr) begin
            wptr_ff <= !wptr_ff;
         end
         if (rd) begin
            rptr_ff <= !rptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         q_ff[wptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== rtl/core/imd_back.sv =====
// Back end of the deframer: message state, byte store and delivery runs.
// Depends on imd_pkg.
module imd_back import imd_pkg::*; #(
   parameter int MSG_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [BYTE_W-1:0] rsp_data_byte,
   output logic [APP_W-1:0]  rsp_app_id,
   output logic [LEN_W-1:0]  rsp_msg_length,
   output logic              rsp_last,
   output logic [CNT_W-1:0]  rsp_delivered_count
);

   localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
   localparam logic [LEN_W-1:0] LIMIT = LEN_W'(MSG_BYTES);

   back_state_type state_ff, state_in;

   logic              receiving_ff;
   logic [RCPT_W-1:0] recipient_ff;
   logic [APP_W-1:0]  app_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [CNT_W-1:0]  counter_ff;
   logic [LEN_W-1:0]  run_len_ff;
   logic [LEN_W-1:0]  idx_ff;

   logic [BYTE_W-1:0] mem_ff [MSG_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   logic              p_valid_ff;
   logic              p_last_ff;
   logic [APP_W-1:0]  p_app_ff;
   logic [LEN_W-1:0]  p_len_ff;
   logic [CNT_W-1:0]  p_cnt_ff;

   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [APP_W-1:0]  out_app_ff;
   logic [LEN_W-1:0]  out_len_ff;
   logic              out_last_ff;
   logic [CNT_W-1:0]  out_cnt_ff;

   logic [SEQ_W-1:0]  seq;
   logic              is_start, store_ok, closes, deliver;
   logic              rd_issue, rd_last, move;

   assign seq      = cmd.word[SEQ_LSB +: SEQ_W];
   assign is_start = (cmd.kind == CMD_START);
   assign store_ok = !is_start && receiving_ff && ({1'b0, seq} == len_ff) && (len_ff < LIMIT);
   assign closes   = store_ok && !cmd.word[CONT_BIT];
   assign deliver  = closes && (recipient_ff == cfg.broadcast)
                     && ({1'b0, app_ff} < cfg.app_count) && cfg.mask[app_ff];
   assign rd_last  = ((idx_ff + LEN_W'(1)) == run_len_ff);
   assign move     = p_valid_ff && (!out_valid_ff || rsp_pop);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && deliver) begin
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            if (rd_issue && rd_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      cmd_pop  = 1'b0;
      rd_issue = 1'b0;
      unique case (state_ff)
         BK_IDLE: cmd_pop  = cmd_valid;
         BK_RUN:  rd_issue = !p_valid_ff || move;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         receiving_ff <= 1'b0;
         recipient_ff <= '0;
         app_ff       <= '0;
         len_ff       <= '0;
         counter_ff   <= '0;
         run_len_ff   <= '0;
         idx_ff       <= '0;
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd_pop) begin
            if (is_start) begin
               receiving_ff <= 1'b1;
               len_ff       <= '0;
               recipient_ff <= cmd.word[RCPT_LSB +: RCPT_W];
               app_ff       <= cmd.word[APP_W-1:0];
            end else if (store_ok) begin
               len_ff <= len_ff + LEN_W'(1);
               if (closes) begin
                  receiving_ff <= 1'b0;
               end
               if (deliver) begin
                  counter_ff <= counter_ff + CNT_W'(1);
                  run_len_ff <= len_ff + LEN_W'(1);
                  idx_ff     <= '0;
               end
            end
         end
         if (rd_issue) begin
            idx_ff <= idx_ff + LEN_W'(1);
         end
         if (rd_issue) begin
            p_valid_ff <= 1'b1;
         end else if (move) begin
            p_valid_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Byte store write port
   always_ff @(posedge clock) begin
      if (cmd_pop && store_ok) begin
         mem_ff[len_ff[AW-1:0]] <= cmd.word[BYTE_W-1:0];
      end
   end

   // Byte store read port and run metadata
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         rd_data_ff <= mem_ff[idx_ff[AW-1:0]];
         p_last_ff  <= rd_last;
         p_app_ff   <= app_ff;
         p_len_ff   <= run_len_ff;
         p_cnt_ff   <= counter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_byte_ff <= rd_data_ff;
         out_app_ff  <= p_app_ff;
         out_len_ff  <= p_len_ff;
         out_last_ff <= p_last_ff;
         out_cnt_ff  <= p_cnt_ff;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_data_byte       = out_byte_ff;
   assign rsp_app_id          = out_app_ff;
   assign rsp_msg_length      = out_len_ff;
   assign rsp_last            = out_last_ff;
   assign rsp_delivered_count = out_cnt_ff;

endmodule

// ===== rtl/core/imd_checker.sv =====
// Port-level checks of the IR message deframer, bound to the top level.
// Depends on imd_pkg and ir_message_deframer_defines.svh.
`include "ir_message_deframer_defines.svh"

module imd_checker import imd_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic [BYTE_W-1:0]    rsp_data_byte,
   input logic [APP_W-1:0]     rsp_app_id,
   input logic [LEN_W-1:0]     rsp_msg_length,
   input logic                 rsp_last,
   input logic [CNT_W-1:0]     rsp_delivered_count
);

   // Hold a stalled result word.
   `IMD_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_data_byte) && $stable(rsp_last)
      && $stable(rsp_delivered_count))

   // A delivered run is never empty and never exceeds the store.
   `IMD_ASSERT_NOW(a_len_range, clock, reset, !rsp_empty,
      (rsp_msg_length != 7'd0) && (rsp_msg_length <= 7'd64))

   // A run streams without gaps: after a non-final byte the next byte of the
   // same message is already waiting.
   `IMD_ASSERT_NEXT(a_run_gapless, clock, reset, !rsp_empty && rsp_pop && !rsp_last,
      !rsp_empty && (rsp_delivered_count == $past(rsp_delivered_count))
      && (rsp_app_id == $past(rsp_app_id)) && (rsp_msg_length == $past(rsp_msg_length)))

endmodule

bind ir_message_deframer imd_checker u_checker (.*);
